[rtl/edfrq_pkg.sv]
// Package for the EDF ready queue: field widths, command and status codes,
// beat and entry structs shared by the queue, its compare unit and its checker.
// No dependencies.
package edfrq_pkg;

	localparam int unsigned ID_W            = 8;
	localparam int unsigned DL_W            = 32;
	localparam int unsigned CMD_W           = 2;
	localparam int unsigned STATUS_W        = 3;
	localparam int unsigned OCC_W           = 5;
	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ     = 2'd0,
		CMD_SET_RDY = 2'd1,
		CMD_DEQ     = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_DUP        = 3'd1,
		ST_FULL       = 3'd2,
		ST_NONE_READY = 3'd3,
		ST_NOT_QUEUED = 3'd4
	} status_e;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0]  task_id;
		logic [DL_W-1:0]  task_deadline;
		logic             task_ready;
	} req_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     picked_id;
		logic [DL_W-1:0]     picked_deadline;
		logic [OCC_W-1:0]    occupancy;
	} rsp_beat_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [DL_W-1:0] deadline;
		logic            ready;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic id_match;
		logic dl_later;
		logic ready;
	} cmp_res_t;

endpackage

[rtl/edf_ready_queue_top.sv]
// Earliest-deadline-first ready queue: sequencer, entry RAM and compare unit.
// Depends on edfrq_pkg, edfrq_ram and edfrq_cmp.
//
//   Channel | Signals                   | Direction | Payload
//   --------+---------------------------+-----------+------------------------------
//   req     | req_valid, req_stall, req | into      | cmd, task id/deadline/ready
//   rsp     | rsp_valid, rsp_stall, rsp | out of    | status, picked id/deadline,
//           |                           |           | occupancy
//
// The single RAM read port sets the pace: the sequencer walks the entries one
// per cycle, once to search and, for an enqueue that is accepted, once more to
// shift the entries behind the insertion point one place back; a no-op command
// goes straight to the response.
// Reset clears the occupancy and the sequencer; the entry RAM is not cleared,
// since only entries below the occupancy are ever read. The block takes no new
// request until the previous one is finished, and a finished response waits in
// the output register while rsp_stall is high.
module edf_ready_queue_top
	import edfrq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	state_t           state_q;
	cmd_e             cmd_q;
	logic [ID_W-1:0]  id_q;
	logic [DL_W-1:0]  dl_q;
	logic             rdy_q;
	logic [CNT_W-1:0] count_q;
	// Read pointer during the search; write target pointer during the shift.
	logic [CNT_W-1:0] walk_q;
	logic [CNT_W-1:0] pos_q;
	logic             found_q;
	logic             dup_q;
	logic [ID_W-1:0]  pid_q;
	logic [DL_W-1:0]  pdl_q;
	status_e          status_q;
	logic             rsp_valid_q;
	rsp_beat_t        rsp_q;

	// Read data of the RAM belongs to the index issued in the previous cycle.
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_ent;
	entry_t           rd_ent;
	logic [ENTRY_W-1:0] rd_raw;
	cmp_res_t         cmp;

	logic             scan_issue;
	logic             shift_issue;
	logic             scan_end;
	logic             shift_end;
	logic [CNT_W-1:0] walk_dec;
	logic             req_take;
	logic             rsp_free;

	edfrq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	assign rd_ent = entry_t'(rd_raw);

	edfrq_cmp u_cmp (
		.ent    (rd_ent),
		.key_id (id_q),
		.key_dl (dl_q),
		.res    (cmp)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign walk_dec    = walk_q - CNT_W'(1);
	assign scan_issue  = (state_q == S_SCAN) && (walk_q != count_q);
	assign shift_issue = (state_q == S_SHIFT) && (walk_q != pos_q);
	assign scan_end    = (state_q == S_SCAN) && (walk_q == count_q) && !vld_s1;
	assign shift_end   = (state_q == S_SHIFT) && (walk_q == pos_q) && !vld_s1;

	// The search reads upward from the head; the enqueue shift reads downward
	// from the tail, each entry being written one place further back.
	always_comb begin
		rd_en   = scan_issue || shift_issue;
		rd_addr = scan_issue ? walk_q[IDX_W-1:0] : walk_dec[IDX_W-1:0];
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_ent  = rd_ent;
		priority if (state_q == S_SCAN && vld_s1 && cmd_q == CMD_SET_RDY
				&& !found_q && cmp.id_match) begin
			// Rewrite the matching entry with the new ready flag.
			wr_en        = 1'b1;
			wr_ent.ready = rdy_q;
		end else if (state_q == S_SCAN && vld_s1 && cmd_q == CMD_DEQ && found_q) begin
			// Entries behind the picked one move one place toward the head.
			wr_en   = 1'b1;
			wr_addr = idx_s1 - IDX_W'(1);
		end else if (state_q == S_SHIFT && vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = idx_s1 + IDX_W'(1);
		end else if (shift_end) begin
			// The gap is open: drop the new task into it.
			wr_en           = 1'b1;
			wr_addr         = pos_q[IDX_W-1:0];
			wr_ent.id       = id_q;
			wr_ent.deadline = dl_q;
			wr_ent.ready    = rdy_q;
		end else begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			vld_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			dup_q       <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			idx_s1 <= rd_addr;
			// The done state loads the next beat itself when the register frees.
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						cmd_q    <= cmd_e'(req.cmd);
						id_q     <= req.task_id;
						dl_q     <= req.task_deadline;
						rdy_q    <= req.task_ready;
						walk_q   <= '0;
						pos_q    <= count_q;
						found_q  <= 1'b0;
						dup_q    <= 1'b0;
						pid_q    <= '0;
						pdl_q    <= '0;
						status_q <= ST_OK;
						state_q  <= (cmd_e'(req.cmd) == CMD_NOP) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						walk_q <= walk_q + CNT_W'(1);
					end
					if (vld_s1) begin
						unique case (cmd_q)
							CMD_ENQ: begin
								if (cmp.id_match) begin
									dup_q <= 1'b1;
								end
								if (!found_q && cmp.dl_later) begin
									found_q <= 1'b1;
									pos_q   <= CNT_W'(idx_s1);
								end
							end
							CMD_SET_RDY: begin
								if (cmp.id_match) begin
									found_q <= 1'b1;
								end
							end
							CMD_DEQ: begin
								if (!found_q && cmp.ready) begin
									found_q <= 1'b1;
									pid_q   <= rd_ent.id;
									pdl_q   <= rd_ent.deadline;
								end
							end
							default: begin
							end
						endcase
					end
					if (scan_end) begin
						state_q <= S_DONE;
						unique case (cmd_q)
							CMD_ENQ: begin
								if (dup_q) begin
									status_q <= ST_DUP;
								end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
									status_q <= ST_FULL;
								end else begin
									walk_q  <= count_q;
									state_q <= S_SHIFT;
								end
							end
							CMD_SET_RDY: begin
								status_q <= found_q ? ST_OK : ST_NOT_QUEUED;
							end
							CMD_DEQ: begin
								if (found_q) begin
									count_q <= count_q - CNT_W'(1);
								end else begin
									status_q <= ST_NONE_READY;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (shift_issue) begin
						walk_q <= walk_dec;
					end
					if (shift_end) begin
						count_q <= count_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q           <= 1'b1;
						rsp_q.status          <= status_q;
						rsp_q.picked_id       <= pid_q;
						rsp_q.picked_deadline <= pdl_q;
						rsp_q.occupancy       <= OCC_W'(count_q);
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/edfrq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module edfrq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/edfrq_cmp.sv]
// Shared compare unit: checks one stored entry against the request key.
// Depends on edfrq_pkg.
module edfrq_cmp
	import edfrq_pkg::*;
(
	input  entry_t          ent,
	input  logic [ID_W-1:0] key_id,
	input  logic [DL_W-1:0] key_dl,
	output cmp_res_t        res
);

	always_comb begin
		res.id_match = (ent.id == key_id);
		// A new entry goes behind every entry whose deadline is not later.
		res.dl_later = (ent.deadline > key_dl);
		res.ready    = ent.ready;
	end

endmodule

[rtl/edfrq_chk.sv]
// Port-level checker for the EDF ready queue, bound to the top level.
// Depends on edfrq_pkg and edf_ready_queue_top.
module edfrq_chk
	import edfrq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_beat_t rsp
);

	// A held response beat keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// The queue works on one request at a time.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while the previous one is in flight");

	// Only a successful dequeue carries a picked task.
	a_pick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.picked_id == '0
			&& rsp.picked_deadline == '0)
		else $error("picked task shown on a failed operation");

	// A full report means the queue holds every slot.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.occupancy == OCC_W'(QUEUE_DEPTH))
		else $error("queue full reported below capacity");

endmodule

bind edf_ready_queue_top edfrq_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_edfrq_chk (.*);

[sim/edf_ready_queue_top_test.sv]
// Self-checking bench for edf_ready_queue_top: sorted insert, set-ready, dequeue and error statuses.
// A scoreboard class predicts every response from the accepted requests.
// Depends on edfrq_pkg and the edf_ready_queue_top RTL.
module edf_ready_queue_top_test
	import edfrq_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH      = QUEUE_DEPTH_DEF;
	localparam int RAND_BEATS  = 1020;
	localparam int QUIET_TAIL  = 150;   // final random beats sent with no idling
	localparam int STALL_LIMIT = 5000;  // cycles with no beat on either channel
	localparam int MAX_PRINTS  = 50;

	// The scoreboard keeps its own copy of the queue, ordered by deadline.
	// It is updated in request order, and it queues one expected response
	// per accepted request beat.
	class ready_queue_scoreboard;
		entry_t    slots[QDEPTH];
		int        count;
		rsp_beat_t pending_rsp[$];
		int        errors;

		function new();
			count  = 0;
			errors = 0;
		endfunction

		// Returns the slot that holds this id, or -1 if the id is not queued.
		function int find_slot(logic [ID_W-1:0] id);
			for (int i = 0; i < count; i++) begin
				if (slots[i].id == id)
					return i;
			end
			return -1;
		endfunction

		function void note_request(req_beat_t r);
			rsp_beat_t e;
			int        pos;
			int        hit;
			e        = '0;
			e.status = ST_OK;
			hit      = find_slot(r.task_id);
			case (cmd_e'(r.cmd))
				CMD_ENQ: begin
					// The duplicate check wins over the full check, and it
					// applies wherever the new entry would land, head included.
					if (hit >= 0) begin
						e.status = ST_DUP;
					end else if (count >= QDEPTH) begin
						e.status = ST_FULL;
					end else begin
						pos = 0;
						while (pos < count && slots[pos].deadline <= r.task_deadline)
							pos++;
						for (int i = count; i > pos; i--)
							slots[i] = slots[i-1];
						slots[pos].id       = r.task_id;
						slots[pos].deadline = r.task_deadline;
						slots[pos].ready    = r.task_ready;
						count++;
					end
				end
				CMD_SET_RDY: begin
					if (hit >= 0)
						slots[hit].ready = r.task_ready;
					else
						e.status = ST_NOT_QUEUED;
				end
				CMD_DEQ: begin
					pos = 0;
					while (pos < count && !slots[pos].ready)
						pos++;
					if (pos < count) begin
						e.picked_id       = slots[pos].id;
						e.picked_deadline = slots[pos].deadline;
						for (int i = pos; i + 1 < count; i++)
							slots[i] = slots[i+1];
						count--;
					end else begin
						e.status = ST_NONE_READY;
					end
				end
				default: ;
			endcase
			e.occupancy = OCC_W'(count);
			pending_rsp.push_back(e);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("MISMATCH @%0t: %s", $time, msg);
		endtask

		task check_response(rsp_beat_t got);
			rsp_beat_t e;
			if (pending_rsp.size() == 0) begin
				report($sformatf("unexpected response %h", got));
			end else begin
				e = pending_rsp.pop_front();
				if (got.status !== e.status)
					report($sformatf("status %0d, want %0d", got.status, e.status));
				if (got.picked_id !== e.picked_id)
					report($sformatf("picked_id %h, want %h", got.picked_id, e.picked_id));
				if (got.picked_deadline !== e.picked_deadline)
					report($sformatf("picked_deadline %h, want %h",
						got.picked_deadline, e.picked_deadline));
				if (got.occupancy !== e.occupancy)
					report($sformatf("occupancy %0d, want %0d", got.occupancy, e.occupancy));
			end
		endtask

		task flush_leftovers();
			while (pending_rsp.size() != 0) begin
				report($sformatf("no response for expected %h", pending_rsp.pop_front()));
			end
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_beat_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_beat_t rsp;

	bit        idling = 1'b1;  // random gaps and stalls are allowed while set
	int        quiet_cycles = 0;

	ready_queue_scoreboard sb = new();

	edf_ready_queue_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Both channels are sampled at the rising edge. A request beat updates the
	// model before the driver picks the next beat at the following falling edge,
	// so the stimulus can look at what is queued right now.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
		end
	end

	// Watchdog: a correct block keeps moving beats, even with the longest enqueue
	// walk, a full stall burst and a sender gap.
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("edf_ready_queue_top test failed");
		$finish;
	end

	// Receiver back-pressure: stall bursts that start at a random cycle, so they
	// land on every phase of the sequencer's walk.
	initial begin
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 5) == 0) begin
				rsp_stall = 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				rsp_stall = 1'b0;
			end
		end
	end

	function automatic req_beat_t make_req(cmd_e c, logic [ID_W-1:0] id,
		logic [DL_W-1:0] dl, logic rdy);
		req_beat_t r;
		r.cmd           = c;
		r.task_id       = id;
		r.task_deadline = dl;
		r.task_ready    = rdy;
		return r;
	endfunction

	// Presents one request beat from a falling edge and holds it until the
	// block takes it. Valid stays high from one beat to the next unless a
	// random sender gap is put in between.
	task automatic send_beat(req_beat_t r);
		if (idling && $urandom_range(0, 3) == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		req_valid = 1'b1;
		req       = r;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	// Random beats with content that stays meaningful: set-ready mostly names a
	// queued id, some enqueues repeat a queued id, and deadlines are often drawn
	// from a tiny range so that ties are common. The filling flag tilts the mix
	// toward enqueues so the queue runs full, and otherwise toward dequeues so
	// it runs dry.
	function automatic req_beat_t random_beat(bit filling);
		req_beat_t   r;
		int unsigned roll;
		r.task_id       = ID_W'($urandom_range(0, 255));
		r.task_deadline = $urandom;
		r.task_ready    = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (roll < 3)
			r.cmd = CMD_NOP;
		else if (roll < (filling ? 60 : 30))
			r.cmd = CMD_ENQ;
		else if (roll < (filling ? 75 : 55))
			r.cmd = CMD_SET_RDY;
		else
			r.cmd = CMD_DEQ;
		case ($urandom_range(0, 3))
			0: r.task_deadline = DL_W'($urandom_range(0, 7));
			1: r.task_deadline = $urandom_range(0, 1) ? '1 : '0;
			default: ;
		endcase
		if (sb.count > 0) begin
			if (r.cmd == CMD_ENQ && $urandom_range(0, 6) == 0)
				r.task_id = sb.slots[$urandom_range(0, sb.count - 1)].id;
			if (r.cmd == CMD_SET_RDY && $urandom_range(0, 4) != 0)
				r.task_id = sb.slots[$urandom_range(0, sb.count - 1)].id;
		end
		return r;
	endfunction

	initial begin
		bit filling;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed opening: the empty queue, an unknown id, the unused command.
		send_beat(make_req(CMD_DEQ, 8'h00, '1, 1'b1));
		send_beat(make_req(CMD_SET_RDY, 8'h00, '0, 1'b1));
		send_beat(make_req(CMD_NOP, 8'hFF, '1, 1'b1));
		// Latest possible deadline at the tail, earliest at the head, then the
		// tail id again with the earliest deadline, which would put it ahead of the tail: it must
		// still be seen as a duplicate.
		send_beat(make_req(CMD_ENQ, 8'h00, '1, 1'b0));
		send_beat(make_req(CMD_ENQ, 8'hFF, '0, 1'b1));
		send_beat(make_req(CMD_ENQ, 8'h00, '0, 1'b1));
		// Equal deadlines: the newer entry goes behind the older one.
		send_beat(make_req(CMD_ENQ, 8'h55, 32'hAAAA_5555, 1'b0));
		send_beat(make_req(CMD_ENQ, 8'hAA, 32'hAAAA_5555, 1'b1));
		// The ready head goes first, then a not-ready entry is skipped, then
		// nothing is left that is ready.
		send_beat(make_req(CMD_DEQ, 8'h00, '0, 1'b0));
		send_beat(make_req(CMD_DEQ, 8'h00, '0, 1'b0));
		send_beat(make_req(CMD_DEQ, 8'h00, '0, 1'b0));
		send_beat(make_req(CMD_SET_RDY, 8'h55, '0, 1'b1));
		// Fill to the brim, then a new id is refused as full while a queued id
		// is still reported as a duplicate.
		for (int i = 0; i < QDEPTH - 2; i++)
			send_beat(make_req(CMD_ENQ, 8'(8'h10 + i), $urandom,
				1'($urandom_range(0, 1))));
		send_beat(make_req(CMD_ENQ, 8'hF0, 32'h0000_0001, 1'b1));
		send_beat(make_req(CMD_ENQ, 8'h55, 32'h0000_0001, 1'b1));

		// Random part. The bias toggles every few dozen beats so the queue
		// swings between full and empty many times.
		filling = 1'b0;
		for (int n = 0; n < RAND_BEATS; n++) begin
			if (n % 60 == 0)
				filling = !filling;
			if (n == RAND_BEATS - QUIET_TAIL)
				idling = 1'b0;
			send_beat(random_beat(filling));
		end
		req_valid = 1'b0;

		// Drain: every response must arrive, then a short settle for anything
		// the block might still emit on its own.
		while (sb.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		sb.flush_leftovers();
		if (sb.errors == 0)
			$display("edf_ready_queue_top test passed");
		else
			$display("edf_ready_queue_top test failed");
		$finish;
	end

endmodule

[files.f]
rtl/edfrq_pkg.sv
rtl/edfrq_ram.sv
rtl/edfrq_cmp.sv
rtl/edf_ready_queue_top.sv
rtl/edfrq_chk.sv
sim/edf_ready_queue_top_test.sv
